### rtl/chs_pkg.sv
`timescale 1ns / 1ps

package chs_pkg;

   // set geometry
   localparam int BUCKETS          = 769;
   localparam int SLOTS_PER_BUCKET = 4;

   localparam int KEY_W  = 31;
   localparam int CMD_W  = 2;
   localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int SLOT_W = (SLOTS_PER_BUCKET > 1) ? $clog2(SLOTS_PER_BUCKET) : 1;

   // reciprocal for key mod BUCKETS: quotient = (key * REC_MULT) >> REC_SHIFT,
   // exact for every key below 2**KEY_W
   localparam int          REC_W      = 32;
   localparam int          REC_SHIFT  = KEY_W + $clog2(BUCKETS);
   localparam logic [63:0] REC_FULL   = ((64'd1 << REC_SHIFT) + 64'(BUCKETS) - 64'd1)
                                        / 64'(BUCKETS);
   localparam logic [REC_W-1:0] REC_MULT = REC_FULL[REC_W-1:0];
   localparam int          PROD_W     = KEY_W + REC_W;
   localparam logic [KEY_W-1:0] BUCKETS_K = KEY_W'(BUCKETS);
   localparam logic [BKT_W-1:0] LAST_BKT  = BKT_W'(BUCKETS - 1);

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef enum logic [CMD_W-1:0] {
      CMD_ADD,
      CMD_REMOVE,
      CMD_QUERY
   } cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic found;
      logic bucket_full;
   } rsp_type;

   // classified request as it travels to the back end
   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [KEY_W-1:0] key;
      logic [BKT_W-1:0] bucket;
   } job_type;

   // one bucket: valid bits and keys of all its slots
   typedef struct packed {
      logic [SLOTS_PER_BUCKET-1:0]            valid;
      logic [SLOTS_PER_BUCKET-1:0][KEY_W-1:0] keys;
   } row_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_LOOK
   } back_state_type;

endpackage

### rtl/chs_front.sv
`timescale 1ns / 1ps

module chs_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept_en,
   input  logic             req_valid,
   output logic             req_ready,
   input  chs_pkg::req_type req_data,
   output logic             push_valid,
   input  logic             push_ready,
   output chs_pkg::job_type push_data
);
   import chs_pkg::*;

   logic              s1_valid_ff, s1_valid_in;
   logic [CMD_W-1:0]  s1_cmd_ff;
   logic [KEY_W-1:0]  s1_key_ff;
   logic [PROD_W-1:0] s1_prod_ff;
   logic [PROD_W-1:0] prod_in;

   logic              s2_valid_ff, s2_valid_in;
   job_type           s2_job_ff, s2_job_in;

   logic              accept, s1_adv, s2_adv, s1_free, s2_free;
   logic [KEY_W-1:0]  quo, quo_mul, rem_full;

   // stage handshake
   assign s2_adv    = s2_valid_ff && push_ready;
   assign s2_free   = !s2_valid_ff || push_ready;
   assign s1_adv    = s1_valid_ff && s2_free;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_ready = accept_en && s1_free;
   assign accept    = req_valid && req_ready;

   // reciprocal product of the key
   assign prod_in = req_data.key * REC_MULT;

   // remainder gives the bucket
   assign quo      = KEY_W'(s1_prod_ff >> REC_SHIFT);
   assign quo_mul  = quo * BUCKETS_K;
   assign rem_full = s1_key_ff - quo_mul;

   always_comb begin
      s2_job_in.command = s1_cmd_ff;
      s2_job_in.key     = s1_key_ff;
      s2_job_in.bucket  = rem_full[BKT_W-1:0];
   end

   // stage valid bits
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      s2_valid_in = s2_valid_ff;
      if (s1_adv) begin
         s2_valid_in = 1'b1;
      end else if (s2_adv) begin
         s2_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_cmd_ff  <= req_data.command;
         s1_key_ff  <= req_data.key;
         s1_prod_ff <= prod_in;
      end
      if (s1_adv) begin
         s2_job_ff <= s2_job_in;
      end
   end

   assign push_valid = s2_valid_ff;
   assign push_data  = s2_job_ff;

endmodule

### rtl/chs_queue.sv
`timescale 1ns / 1ps

module chs_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  chs_pkg::job_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output chs_pkg::job_type pop_data
);
   import chs_pkg::*;

   job_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]    count_ff, count_in;
   logic               push, pop;

   assign push_ready = (count_ff != (QPTR_W + 1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/chs_back.sv
`timescale 1ns / 1ps

module chs_back (
   input  logic             clock,
   input  logic             reset,
   output logic             clearing,
   input  logic             pop_valid,
   output logic             pop_ready,
   input  chs_pkg::job_type pop_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output chs_pkg::rsp_type rsp_data
);
   import chs_pkg::*;

   back_state_type    state_ff, state_in;
   logic [BKT_W-1:0]  clr_idx_ff, clr_idx_in;
   job_type           job_ff;
   row_type           mem [BUCKETS];
   row_type           rd_row_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff;

   logic              rd_en, wr_en, rsp_load, clr_step;
   logic [BKT_W-1:0]  wr_addr;
   row_type           wr_row, new_row;
   logic              hit, has_free, done;
   logic [SLOT_W-1:0] hit_idx, free_idx;
   rsp_type           result;

   assign done = !rsp_valid_ff || rsp_ready;

   // slot search in the bucket row
   always_comb begin
      hit      = 1'b0;
      has_free = 1'b0;
      hit_idx  = '0;
      free_idx = '0;
      for (int i = 0; i < SLOTS_PER_BUCKET; i++) begin
         if (rd_row_ff.valid[i]) begin
            if (!hit && rd_row_ff.keys[i] == job_ff.key) begin
               hit     = 1'b1;
               hit_idx = SLOT_W'(i);
            end
         end else if (!has_free) begin
            has_free = 1'b1;
            free_idx = SLOT_W'(i);
         end
      end
   end

   // updated row and result
   always_comb begin
      new_row            = rd_row_ff;
      result.found       = hit;
      result.bucket_full = 1'b0;
      case (job_ff.command)
         CMD_ADD: begin
            if (!hit) begin
               if (has_free) begin
                  new_row.valid[free_idx] = 1'b1;
                  new_row.keys[free_idx]  = job_ff.key;
               end else begin
                  result.bucket_full = 1'b1;
               end
            end
         end
         CMD_REMOVE: begin
            if (hit) begin
               new_row.valid[hit_idx] = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_CLEAR: begin
            if (clr_idx_ff == LAST_BKT) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (pop_valid) begin
               state_in = BK_LOOK;
            end
         end
         BK_LOOK: begin
            if (done) begin
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_CLEAR;
         end
      endcase
   end

   // state outputs
   always_comb begin
      clearing  = 1'b0;
      clr_step  = 1'b0;
      pop_ready = 1'b0;
      rd_en     = 1'b0;
      wr_en     = 1'b0;
      wr_addr   = job_ff.bucket;
      wr_row    = new_row;
      rsp_load  = 1'b0;
      case (state_ff)
         BK_CLEAR: begin
            clearing = 1'b1;
            clr_step = 1'b1;
            wr_en    = 1'b1;
            wr_addr  = clr_idx_ff;
            wr_row   = '0;
         end
         BK_IDLE: begin
            pop_ready = 1'b1;
            rd_en     = pop_valid;
         end
         BK_LOOK: begin
            wr_en    = done;
            rsp_load = done;
         end
         default: begin
         end
      endcase
   end

   assign clr_idx_in = clr_step ? clr_idx_ff + 1'b1 : clr_idx_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_CLEAR;
         clr_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // bucket memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
      if (rd_en) begin
         rd_row_ff <= mem[pop_data.bucket];
      end
   end

   // job and result registers
   always_ff @(posedge clock) begin
      if (rd_en) begin
         job_ff <= pop_data;
      end
      if (rsp_load) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### rtl/chained_hash_set_top.sv
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// request   in         req_valid / req_ready  req_data  {command, key}
// response  out        rsp_valid / rsp_ready  rsp_data  {found, bucket_full}
//
// in the back end each request first reads its bucket row from the bucket memory,
// then compares the slots and writes the row back
// after reset a clearing pass writes every bucket row;
// req_ready stays low until it ends
// a stalled response holds the back end; the front end and queue keep taking
// requests until the queue and the front-end stages fill

module chained_hash_set_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  chs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output chs_pkg::rsp_type rsp_data
);
   import chs_pkg::*;

   logic    clearing;
   logic    fq_valid, fq_ready, qb_valid, qb_ready;
   job_type fq_data, qb_data;

   // key classification and bucket index
   chs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept_en  (!clearing),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data)
   );

   // decoupling queue
   chs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_data)
   );

   // bucket read-modify-write
   chs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .clearing  (clearing),
      .pop_valid (qb_valid),
      .pop_ready (qb_ready),
      .pop_data  (qb_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

### rtl/chs_checker.sv
`timescale 1ns / 1ps

module chs_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input chs_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input chs_pkg::rsp_type rsp_data
);
   import chs_pkg::*;

   // a dropped add never reports the key as present
   a_full_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.bucket_full && rsp_data.found))
      else $error("bucket_full and found both set");

   // clearing pass blocks requests right after reset
   a_clear_blocks: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request taken during clearing pass");

   // no response right after reset
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

endmodule

bind chained_hash_set_top chs_checker u_chs_checker (.*);
